// File: src/ppf_pkg.sv
package ppf_pkg;

    // Stream widths, whole bytes
    localparam int IN_W    = 192;
    localparam int OUT_W   = 152;
    localparam int SLOT_FW = 6;
    localparam int GRP_W   = 8;

    localparam logic FUNC_SPAWN = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ST_SPAWNED = 2'd0,
        ST_FULL    = 2'd1,
        ST_LIVE    = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND1,
        S_FIND2,
        S_PICK,
        S_DIV,
        S_SPAWN,
        S_FULL,
        S_SCAN,
        S_MOD,
        S_FLUSH
    } state_t;

    // One slot as held in the slot memory
    typedef struct packed {
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] pos_z;
        logic [15:0] vel_x;
        logic [15:0] vel_z;
        logic [23:0] rgb;
        logic [15:0] alpha;
        logic [15:0] step;
        logic [15:0] ticks;
        logic [15:0] height;
        logic [15:0] width;
    } slot_rec_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_FW-1:0]   slot;
        logic [23:0]          cur_x;
        logic [23:0]          cur_y;
        logic [23:0]          cur_z;
        logic [23:0]          out_rgb;
        logic [15:0]          cur_alpha;
        logic [15:0]          out_width;
        logic [15:0]          out_height;
        logic                 last;
    } res_t;

endpackage

// File: src/ppf_ram.sv
module ppf_ram
    import ppf_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  slot_rec_t         wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output slot_rec_t         rdata
);

    slot_rec_t mem [DEPTH];
    slot_rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/ppf_div.sv
module ppf_div
    import ppf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [15:0] quotient
);

    localparam int STEPS = 16;
    localparam int CNT_W = $clog2(STEPS);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      rem_reg;
    logic [15:0]      quo_reg;
    logic [15:0]      dvs_reg;
    logic [16:0]      shifted;
    logic [17:0]      diff;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg, quo_reg[15]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[17] ? shifted[15:0] : diff[15:0];
            quo_reg <= {quo_reg[14:0], ~diff[17]};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: src/ppf_find.sv
module ppf_find
    import ppf_pkg::*;
#(
    parameter int POOL_SIZE = 64
)
(
    input  logic                 clk,
    input  logic [POOL_SIZE-1:0] free,
    output logic                 found,
    output logic [SLOT_FW-1:0]   slot
);

    localparam int NGRP = (POOL_SIZE + GRP_W - 1) / GRP_W;

    logic [NGRP*GRP_W-1:0] free_pad;
    logic                  grp_any_next [NGRP];
    logic [2:0]            grp_idx_next [NGRP];
    logic                  grp_any_reg  [NGRP];
    logic [2:0]            grp_idx_reg  [NGRP];
    logic                  found_next;
    logic [SLOT_FW-1:0]    slot_next;
    logic                  found_reg;
    logic [SLOT_FW-1:0]    slot_reg;

    // padding slots read as taken
    assign free_pad = (NGRP*GRP_W)'(free);

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int b = GRP_W - 1; b >= 0; b--)
            begin
                if (free_pad[g*GRP_W + b])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_idx_next[g] = 3'(b);
                end
            end
        end
    end

    always_comb
    begin
        found_next = 1'b0;
        slot_next  = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                found_next = 1'b1;
                slot_next  = {3'(g), grp_idx_reg[g]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_any_reg[g] <= grp_any_next[g];
            grp_idx_reg[g] <= grp_idx_next[g];
        end
        found_reg <= found_next;
        slot_reg  <= slot_next;
    end

    assign found = found_reg;
    assign slot  = slot_reg;

endmodule

// File: src/particle_pool_fade_engine.sv
// Pool of up to POOL_SIZE fading particles. A spawn (s_tuser 0) takes the lowest free
// slot and returns one transfer with status spawned, or pool full; its fade step comes
// from the 16-step divider. A tick (s_tuser 1) walks the slot memory one free entry
// per cycle; each live slot passes through a read-modify-write state that can wait on
// the output. It returns one transfer per live slot in slot order, or a single
// "none live" transfer, tlast marking the final one. Occupancy flags sit in flip-flops
// cleared by reset, so there is no clearing pass; slot data is only read for occupied
// slots.
module particle_pool_fade_engine
    import ppf_pkg::*;
#(
    parameter int POOL_SIZE = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // start_x, start_y, start_z, velocity_x, velocity_z, tint_rgb, start_alpha,
    // width, height, lifetime
    input  logic [IN_W-1:0]  s_tdata,
    // func
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // slot, cur_x, cur_y, cur_z, out_rgb, cur_alpha, out_width, out_height, 2 pad bits
    output logic [OUT_W-1:0] m_tdata,
    // status
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W = $clog2(POOL_SIZE + 1);

    state_t               state_reg, state_next;
    logic [POOL_SIZE-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 pend_valid_reg, pend_valid_next;
    slot_rec_t            spawn_rec_reg;
    logic [IDX_W-1:0]     slot_reg;
    res_t                 out_reg;
    res_t                 pend_reg;

    slot_rec_t            in_rec;
    logic [15:0]          life_in;
    logic [15:0]          life_nz;
    logic [IDX_W-1:0]     scan_idx;
    logic                 out_free;
    logic                 out_load;
    res_t                 out_data;
    logic                 pend_load;
    logic                 slot_load;
    logic                 in_take;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    slot_rec_t            ram_wdata;
    logic                 ram_re;
    slot_rec_t            ram_rdata;

    logic                 div_start;
    logic                 div_busy;
    logic [15:0]          div_q;

    logic                 fnd_found;
    logic [SLOT_FW-1:0]   fnd_slot;

    slot_rec_t            tick_rec;
    res_t                 tick_res;
    slot_rec_t            spawn_wr;
    res_t                 spawn_res;

    assign life_in  = s_tdata[191:176];
    assign life_nz  = (life_in == 16'd0) ? 16'd1 : life_in;
    assign scan_idx = scan_cnt_reg[IDX_W-1:0];
    assign out_free = !out_valid_reg || m_tready;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_rec        = '0;
        in_rec.pos_x  = s_tdata[23:0];
        in_rec.pos_y  = s_tdata[47:24];
        in_rec.pos_z  = s_tdata[71:48];
        in_rec.vel_x  = s_tdata[87:72];
        in_rec.vel_z  = s_tdata[103:88];
        in_rec.rgb    = s_tdata[127:104];
        in_rec.alpha  = s_tdata[143:128];
        in_rec.width  = s_tdata[159:144];
        in_rec.height = s_tdata[175:160];
        in_rec.ticks  = life_nz;
    end

    ppf_ram #(
        .DEPTH  (POOL_SIZE),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_idx),
        .rdata (ram_rdata)
    );

    ppf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (in_rec.alpha),
        .divisor  (life_nz),
        .busy     (div_busy),
        .quotient (div_q)
    );

    ppf_find #(
        .POOL_SIZE (POOL_SIZE)
    ) u_find (
        .clk   (clk),
        .free  (~occ_reg),
        .found (fnd_found),
        .slot  (fnd_slot)
    );

    // Tick update of the slot just read
    always_comb
    begin
        tick_rec       = ram_rdata;
        tick_rec.pos_x = ram_rdata.pos_x + {{8{ram_rdata.vel_x[15]}}, ram_rdata.vel_x};
        tick_rec.pos_z = ram_rdata.pos_z + {{8{ram_rdata.vel_z[15]}}, ram_rdata.vel_z};
        tick_rec.alpha = (ram_rdata.alpha > ram_rdata.step) ?
                         (ram_rdata.alpha - ram_rdata.step) : 16'd0;
        tick_rec.ticks = (ram_rdata.ticks != 16'd0) ? (ram_rdata.ticks - 1'b1) : 16'd0;

        tick_res            = '0;
        tick_res.status     = ST_LIVE;
        tick_res.slot       = SLOT_FW'(scan_idx);
        tick_res.cur_x      = tick_rec.pos_x;
        tick_res.cur_y      = tick_rec.pos_y;
        tick_res.cur_z      = tick_rec.pos_z;
        tick_res.out_rgb    = tick_rec.rgb;
        tick_res.cur_alpha  = tick_rec.alpha;
        tick_res.out_width  = tick_rec.width;
        tick_res.out_height = tick_rec.height;
        tick_res.last       = 1'b0;
    end

    always_comb
    begin
        spawn_wr      = spawn_rec_reg;
        spawn_wr.step = div_q;

        spawn_res            = '0;
        spawn_res.status     = ST_SPAWNED;
        spawn_res.slot       = SLOT_FW'(slot_reg);
        spawn_res.cur_x      = spawn_rec_reg.pos_x;
        spawn_res.cur_y      = spawn_rec_reg.pos_y;
        spawn_res.cur_z      = spawn_rec_reg.pos_z;
        spawn_res.out_rgb    = spawn_rec_reg.rgb;
        spawn_res.cur_alpha  = spawn_rec_reg.alpha;
        spawn_res.out_width  = spawn_rec_reg.width;
        spawn_res.out_height = spawn_rec_reg.height;
        spawn_res.last       = 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        scan_cnt_next   = scan_cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_load        = 1'b0;
        out_data        = '0;
        pend_load       = 1'b0;
        pend_valid_next = pend_valid_reg;
        slot_load       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = slot_reg;
        ram_wdata       = spawn_wr;
        ram_re          = 1'b0;
        div_start       = 1'b0;
        s_tready        = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == FUNC_TICK)
                    begin
                        scan_cnt_next   = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_FIND1;
                    end
                end
            end
            // finder is a two-stage registered tree
            S_FIND1:
            begin
                state_next = S_FIND2;
            end
            S_FIND2:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                slot_load  = 1'b1;
                state_next = fnd_found ? S_DIV : S_FULL;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_SPAWN;
                end
            end
            S_SPAWN:
            begin
                if (out_free)
                begin
                    ram_we            = 1'b1;
                    occ_next[slot_reg] = 1'b1;
                    out_load          = 1'b1;
                    out_data          = spawn_res;
                    state_next        = S_IDLE;
                end
            end
            S_FULL:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_data.status = ST_FULL;
                    out_data.last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == CNT_W'(POOL_SIZE))
                begin
                    state_next = S_FLUSH;
                end
                else if (occ_reg[scan_idx])
                begin
                    ram_re     = 1'b1;
                    state_next = S_MOD;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            // previous report goes out only once a later live slot proves it is not last
            S_MOD:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    ram_we             = 1'b1;
                    ram_waddr          = scan_idx;
                    ram_wdata          = tick_rec;
                    occ_next[scan_idx] = (tick_rec.ticks != 16'd0);
                    if (pend_valid_reg)
                    begin
                        out_load = 1'b1;
                        out_data = pend_reg;
                    end
                    pend_load       = 1'b1;
                    pend_valid_next = 1'b1;
                    scan_cnt_next   = scan_cnt_reg + 1'b1;
                    state_next      = S_SCAN;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_data = pend_reg;
                    end
                    else
                    begin
                        out_data.status = ST_NONE;
                    end
                    out_data.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            occ_reg        <= '0;
            scan_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            scan_cnt_reg   <= scan_cnt_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            spawn_rec_reg <= in_rec;
        end
        if (slot_load)
        begin
            slot_reg <= fnd_slot[IDX_W-1:0];
        end
        if (out_load)
        begin
            out_reg <= out_data;
        end
        if (pend_load)
        begin
            pend_reg <= tick_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {2'b00, out_reg.out_height, out_reg.out_width, out_reg.cur_alpha,
                       out_reg.out_rgb, out_reg.cur_z, out_reg.cur_y, out_reg.cur_x,
                       out_reg.slot};

endmodule

// File: src/ppf_checker.sv
module ppf_props
    import ppf_pkg::*;
#(
    parameter int POOL_SIZE = 64
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [1:0]       m_tuser,
    input logic             m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // one item in flight: no back-to-back accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_SPAWNED || m_tuser == ST_FULL || m_tuser == ST_NONE)
        |-> m_tlast)
        else $error("single-result status without tlast");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_NONE) |-> m_tdata == '0)
        else $error("empty result carries data");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_SPAWNED || m_tuser == ST_LIVE)
        |-> m_tdata[SLOT_FW-1:0] < SLOT_FW'(POOL_SIZE - 1) + 1'b1 || POOL_SIZE == 64)
        else $error("slot beyond pool");

endmodule

bind particle_pool_fade_engine ppf_props #(.POOL_SIZE(POOL_SIZE)) u_ppf_props (.*);

// File: test/ppf_checker.sv
module ppf_checker
    import ppf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    input  logic [1:0]       m_tuser,
    input  logic             m_tlast,
    output int               mismatches,
    output int               pending,
    output int               reports,
    output int               full_seen,
    output int               none_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;

    // Spawn payload as carried on s_tdata, first field in the lowest bits
    typedef struct packed {
        logic [15:0] lifetime;
        logic [15:0] height;
        logic [15:0] width;
        logic [15:0] alpha;
        logic [23:0] rgb;
        logic [15:0] vel_z;
        logic [15:0] vel_x;
        logic [23:0] z;
        logic [23:0] y;
        logic [23:0] x;
    } spawn_req_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] height;
        logic [15:0] width;
        logic [15:0] alpha;
        logic [23:0] rgb;
        logic [23:0] z;
        logic [23:0] y;
        logic [23:0] x;
        logic [5:0]  slot;
    } report_bus_t;

    logic [SLOTS-1:0] live;
    logic [23:0]      px   [SLOTS];
    logic [23:0]      py   [SLOTS];
    logic [23:0]      pz   [SLOTS];
    logic [23:0]      tint [SLOTS];
    logic [15:0]      vx   [SLOTS];
    logic [15:0]      vz   [SLOTS];
    logic [15:0]      opac [SLOTS];
    logic [15:0]      fade [SLOTS];
    logic [15:0]      ttl  [SLOTS];
    logic [15:0]      wd   [SLOTS];
    logic [15:0]      ht   [SLOTS];

    res_t due_reports[$];

    function automatic res_t slot_report(input status_t st, input int k);
        res_t e;
        e            = '0;
        e.status     = st;
        e.slot       = 6'(k);
        e.cur_x      = px[k];
        e.cur_y      = py[k];
        e.cur_z      = pz[k];
        e.out_rgb    = tint[k];
        e.cur_alpha  = opac[k];
        e.out_width  = wd[k];
        e.out_height = ht[k];
        return e;
    endfunction

    task automatic spawn_particle(input spawn_req_t r);
        int          k;
        logic [15:0] life;
        res_t        e;
        k = 0;
        while (k < SLOTS && live[k])
            k++;
        if (k == SLOTS)
        begin
            e        = '0;
            e.status = ST_FULL;
        end
        else
        begin
            life    = (r.lifetime == 16'd0) ? 16'd1 : r.lifetime;
            px[k]   = r.x;
            py[k]   = r.y;
            pz[k]   = r.z;
            vx[k]   = r.vel_x;
            vz[k]   = r.vel_z;
            tint[k] = r.rgb;
            opac[k] = r.alpha;
            fade[k] = r.alpha / life;
            ttl[k]  = life;
            wd[k]   = r.width;
            ht[k]   = r.height;
            live[k] = 1'b1;
            e       = slot_report(ST_SPAWNED, k);
        end
        e.last = 1'b1;
        due_reports.push_back(e);
    endtask

    // One report per live slot in slot order; the last one is held back until
    // we know it is the final one so that tlast can be set on it
    task automatic advance_pool();
        int   k;
        res_t held;
        bit   have;
        have = 1'b0;
        for (k = 0; k < SLOTS; k++)
        begin
            if (live[k])
            begin
                px[k]   = px[k] + {{8{vx[k][15]}}, vx[k]};
                pz[k]   = pz[k] + {{8{vz[k][15]}}, vz[k]};
                opac[k] = (opac[k] > fade[k]) ? opac[k] - fade[k] : 16'd0;
                if (ttl[k] != 16'd0)
                    ttl[k] = ttl[k] - 16'd1;
                if (ttl[k] == 16'd0)
                    live[k] = 1'b0;
                if (have)
                    due_reports.push_back(held);
                held = slot_report(ST_LIVE, k);
                have = 1'b1;
            end
        end
        if (!have)
        begin
            held        = '0;
            held.status = ST_NONE;
        end
        held.last = 1'b1;
        due_reports.push_back(held);
    endtask

    function automatic string field_diff(input res_t w, input res_t g);
        string s;
        s = "";
        if (g.status !== w.status)         s = {s, " status"};
        if (g.slot !== w.slot)             s = {s, " slot"};
        if (g.cur_x !== w.cur_x)           s = {s, " cur_x"};
        if (g.cur_y !== w.cur_y)           s = {s, " cur_y"};
        if (g.cur_z !== w.cur_z)           s = {s, " cur_z"};
        if (g.out_rgb !== w.out_rgb)       s = {s, " out_rgb"};
        if (g.cur_alpha !== w.cur_alpha)   s = {s, " cur_alpha"};
        if (g.out_width !== w.out_width)   s = {s, " out_width"};
        if (g.out_height !== w.out_height) s = {s, " out_height"};
        if (g.last !== w.last)             s = {s, " last"};
        return s;
    endfunction

    function automatic string show(input res_t e);
        return $sformatf("status %0d slot %0d x %h y %h z %h rgb %h alpha %h w %h h %h last %b",
                         e.status, e.slot, e.cur_x, e.cur_y, e.cur_z, e.out_rgb,
                         e.cur_alpha, e.out_width, e.out_height, e.last);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t        got;
        res_t        want;
        report_bus_t bus;
        string       diff;
        if (!rst_n)
        begin
            live = '0;
            due_reports.delete();
            mismatches = 0;
            pending    = 0;
            reports    = 0;
            full_seen  = 0;
            none_seen  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == FUNC_SPAWN)
                    spawn_particle(spawn_req_t'(s_tdata));
                else
                    advance_pool();
            end
            if (m_tvalid && m_tready)
            begin
                bus            = report_bus_t'(m_tdata);
                got.status     = status_t'(m_tuser);
                got.slot       = bus.slot;
                got.cur_x      = bus.x;
                got.cur_y      = bus.y;
                got.cur_z      = bus.z;
                got.out_rgb    = bus.rgb;
                got.cur_alpha  = bus.alpha;
                got.out_width  = bus.width;
                got.out_height = bus.height;
                got.last       = m_tlast;
                reports++;
                if (got.status == ST_FULL)
                    full_seen++;
                if (got.status == ST_NONE)
                    none_seen++;
                if (due_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding: %s", $time, show(got));
                end
                else
                begin
                    want = due_reports.pop_front();
                    diff = field_diff(want, got);
                    if (diff != "")
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: report mismatch on%s", $time, diff);
                            $display("    expected %s", show(want));
                            $display("    actual   %s", show(got));
                        end
                    end
                end
            end
            pending = due_reports.size();
        end
    end

endmodule

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ppf_pkg::*;

    localparam int ITEMS_TOTAL = 370;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 150;

    logic             clk;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             s_tuser  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;

    int mismatches;
    int pending;
    int reports;
    int full_seen;
    int none_seen;
    int sent     = 0;
    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    particle_pool_fade_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ppf_checker pool_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending),
        .reports    (reports),
        .full_seen  (full_seen),
        .none_seen  (none_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [IN_W-1:0] pack_spawn(
        input logic [23:0] x, y, z,
        input logic [15:0] vel_x, vel_z,
        input logic [23:0] rgb,
        input logic [15:0] alpha, w, h, life
    );
        return {life, h, w, alpha, rgb, vel_z, vel_x, z, y, x};
    endfunction

    function automatic logic [23:0] rand_coord();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 24'h7FFFFF - 24'($urandom_range(0, 255));
        else if (r < 20)
            return 24'h800000 + 24'($urandom_range(0, 255));
        return 24'($urandom);
    endfunction

    function automatic logic [15:0] rand_vel();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'h7FFF;
        else if (r < 20)
            return 16'h8000;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_alpha();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 16'($urandom_range(0, 40));
        else if (r < 25)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // mostly short lives so slots churn; a few near-permanent ones
    function automatic logic [15:0] rand_life(input int life_hi);
        int r;
        if (life_hi > 0)
            return 16'($urandom_range(1, life_hi));
        r = $urandom_range(99);
        if (r < 8)
            return 16'd0;
        else if (r < 70)
            return 16'($urandom_range(1, 6));
        else if (r < 97)
            return 16'($urandom_range(7, 40));
        return 16'($urandom);
    endfunction

    task automatic push_item(input logic fn, input logic [IN_W-1:0] data);
        while (!calm && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic spawn(
        input logic [23:0] x, y, z,
        input logic [15:0] vel_x, vel_z,
        input logic [23:0] rgb,
        input logic [15:0] alpha, w, h, life
    );
        push_item(FUNC_SPAWN, pack_spawn(x, y, z, vel_x, vel_z, rgb, alpha, w, h, life));
    endtask

    task automatic rand_spawn(input int life_hi);
        spawn(rand_coord(), rand_coord(), rand_coord(), rand_vel(), rand_vel(),
              24'($urandom), rand_alpha(), 16'($urandom), 16'($urandom), rand_life(life_hi));
    endtask

    // payload of a tick is ignored by the block, so fill it with noise
    task automatic tick_pool();
        push_item(FUNC_TICK, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    initial
    begin : drain_side
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= calm || ($urandom_range(99) >= 17);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("No transfer for %0d cycles, giving up", quiet);
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int r;
        bit filled;
        bit held;
        bit paused;
        filled = 1'b0;
        held   = 1'b0;
        paused = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty pool, then the field extremes
        tick_pool();
        spawn(24'h7FFFFF, 24'h800000, 24'h800000, 16'h7FFF, 16'h8000,
              24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        spawn(24'h000000, 24'h7FFFFF, 24'h7FFFFF, 16'h8000, 16'h7FFF,
              24'h000000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001);
        spawn(24'h123456, 24'hFEDCBA, 24'h000100, 16'h0100, 16'hFF00,
              24'h80FF01, 16'hFFFF, 16'h0180, 16'h0240, 16'hFFFF);
        // step rounds to zero: opacity stays put
        spawn(24'h000010, 24'h000020, 24'h000030, 16'h0001, 16'hFFFF,
              24'h0A0B0C, 16'h0005, 16'h0100, 16'h0100, 16'd100);
        // step leaves a remainder, opacity never reaches zero
        spawn(24'hFFFFFF, 24'h000000, 24'h800001, 16'h7FFF, 16'h8001,
              24'h00FF00, 16'd1000, 16'h00FF, 16'hFF00, 16'd3);
        tick_pool();
        // freed slots come back lowest first
        rand_spawn(4);
        rand_spawn(4);
        tick_pool();
        tick_pool();
        tick_pool();
        rand_spawn(0);
        rand_spawn(0);
        tick_pool();
        wait_drained();

        while (sent < ITEMS_TOTAL)
        begin
            calm = (sent >= 90 && sent < 150);
            if (!held && sent >= 120)
            begin
                held     = 1'b1;
                hold_req = 1'b1;
                repeat (4) rand_spawn(30);
                tick_pool();
                repeat (4) rand_spawn(0);
                tick_pool();
            end
            else if (!filled && sent >= 180)
            begin
                filled = 1'b1;
                repeat (70) rand_spawn(12);
                repeat (6) tick_pool();
            end
            else if (!paused && sent >= 270)
            begin
                paused = 1'b1;
                wait_drained();
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 75)
                begin
                    repeat ($urandom_range(1, 5)) rand_spawn(0);
                    repeat ($urandom_range(1, 2)) tick_pool();
                end
                else if (r < 88)
                    repeat ($urandom_range(2, 4)) tick_pool();
                else
                    repeat ($urandom_range(3, 8)) rand_spawn(0);
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (SETTLE) @(negedge clk);

        $display("Sent %0d spawn/tick transfers; checked %0d results, %0d of them pool-full",
                 sent, reports, full_seen);
        $display("and %0d empty-pool ticks, with %0d mismatches.", none_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
src/ppf_pkg.sv
src/ppf_ram.sv
src/ppf_div.sv
src/ppf_find.sv
src/particle_pool_fade_engine.sv
src/ppf_checker.sv
test/ppf_checker.sv
test/testbench.sv
